// File: rtl/ialu_pkg.sv
package ialu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned CMDW = 4;
	localparam int unsigned DIV_BITS_PER_STAGE = 4;
	localparam int unsigned DIV_STAGES = XLEN / DIV_BITS_PER_STAGE;

	localparam logic [XLEN-1:0] HIGH_HALF_MASK = 32'hFFFF_0000;
	localparam logic [XLEN-1:0] LOW_HALF_MASK  = 32'h0000_FFFF;

	typedef enum logic [CMDW-1:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_CMP = 4'd4,
		CMD_SHL = 4'd5,
		CMD_SHR = 4'd6,
		CMD_SAR = 4'd7,
		CMD_AND = 4'd8,
		CMD_OR  = 4'd9,
		CMD_XOR = 4'd10,
		CMD_NOT = 4'd11,
		CMD_LDL = 4'd12,
		CMD_LDH = 4'd13
	} cmd_t;

	// data carried down the divider pipe
	typedef struct packed {
		logic [XLEN-1:0] quo;   // dividend bits shift out, quotient bits shift in
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] den;   // divisor magnitude
		logic [XLEN-1:0] b;     // original divisor
		logic            neg_a;
		logic            neg_b;
	} div_data_t;

	// side info for the non-divide result, carried alongside
	typedef struct packed {
		logic [XLEN-1:0] res;
		logic            is_div;
		logic            div_zero;
		logic            fw;
		logic            rw;
	} res_info_t;

endpackage

// File: rtl/integer_alu_floored_division.sv
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, command, operand_a/b  | into block
// out     | out_valid, out_ready, result_value, ...   | out of block
//
// Every command passes the input register, 8 divider stages of 4 bits and the
// output register (with the floored fixup in front of it); one transaction per
// cycle sustained while out_ready stays high.
// The divider stage chain sets the depth; mul lands in the first register.
// arst_n clears all valid bits. A stall on out_ready freezes the whole
// pipe, so in_ready drops only while a held output waits for out_ready.
module integer_alu_floored_division (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ialu_pkg::CMDW-1:0]   command,
	input  logic [ialu_pkg::XLEN-1:0]   operand_a,
	input  logic [ialu_pkg::XLEN-1:0]   operand_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ialu_pkg::XLEN-1:0]   result_value,
	output logic [ialu_pkg::XLEN-1:0]   remainder_value,
	output logic                        negative_flag,
	output logic                        zero_flag,
	output logic                        flags_written,
	output logic                        result_written,
	output logic                        error_code
);
	import ialu_pkg::*;

	localparam int unsigned NS = DIV_STAGES + 1;

	res_info_t info_c;
	div_data_t dinit_c;
	logic      is_mul_c;

	logic      adv;
	logic      v_s  [1:NS];
	res_info_t i_s  [1:NS];
	div_data_t d_s  [1:NS];
	div_data_t dn_c [DIV_STAGES];
	logic [XLEN-1:0] prod_s1;
	logic            mul_s1;

	logic [XLEN-1:0] qm, rm, qt, rt, fres, frem;

	ialu_front u_front (
		.command  (command),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.info     (info_c),
		.dinit    (dinit_c)
	);

	assign is_mul_c = (command == CMD_MUL);
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1 registers inputs; stages 2..NS each run one divider step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			i_s[1]  <= info_c;
			d_s[1]  <= dinit_c;
			prod_s1 <= operand_a * operand_b;
			mul_s1  <= is_mul_c;
			for (int k = 2; k <= NS; k++) begin
				i_s[k] <= (k == 2 && mul_s1) ?
					res_info_t'{res: prod_s1, is_div: 1'b0, div_zero: 1'b0,
						fw: 1'b1, rw: 1'b1} :
					i_s[k-1];
				d_s[k] <= dn_c[k-2];
			end
		end
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ialu_div_stage u_stage (.din(d_s[g+1]), .dout(dn_c[g]));
	end

	// floored fixup and output register
	always_comb begin
		qm = d_s[NS].quo;
		rm = d_s[NS].rem;
		qt = (d_s[NS].neg_a != d_s[NS].neg_b) ? (XLEN'(0) - qm) : qm;
		rt = d_s[NS].neg_a ? (XLEN'(0) - rm) : rm;
		if (rm != '0 && d_s[NS].neg_a != d_s[NS].neg_b) begin
			qt = qt - XLEN'(1);
			rt = rt + d_s[NS].b;
		end
		fres = i_s[NS].res;
		frem = '0;
		if (i_s[NS].is_div && !i_s[NS].div_zero) begin
			fres = qt;
			frem = rt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_value    <= fres;
			remainder_value <= frem;
			negative_flag   <= fres[XLEN-1];
			zero_flag       <= (fres == '0);
			flags_written   <= i_s[NS].fw;
			result_written  <= i_s[NS].rw;
			error_code      <= i_s[NS].div_zero;
		end
	end

endmodule

// File: rtl/ialu_front.sv
// Stage-one combinational front end: simple ops, shifts and divider setup.
// mul is produced one stage later (registered product).
module ialu_front (
	input  logic [ialu_pkg::CMDW-1:0] command,
	input  logic [ialu_pkg::XLEN-1:0] operand_a,
	input  logic [ialu_pkg::XLEN-1:0] operand_b,
	output ialu_pkg::res_info_t       info,
	output ialu_pkg::div_data_t       dinit
);
	import ialu_pkg::*;

	logic            big_shift;
	logic [4:0]      sh;
	logic [XLEN-1:0] fill;

	always_comb begin
		big_shift = |operand_b[XLEN-1:5];
		sh = operand_b[4:0];
		fill = {XLEN{operand_a[XLEN-1]}};
		info = '{res: operand_a, is_div: 1'b0, div_zero: 1'b0, fw: 1'b1, rw: 1'b1};
		unique case (command)
			CMD_ADD: info.res = operand_a + operand_b;
			CMD_SUB: info.res = operand_a - operand_b;
			CMD_MUL: info.res = '0;
			CMD_DIV: begin
				info.is_div = 1'b1;
				info.res = '0;
				if (operand_b == '0) begin
					info.div_zero = 1'b1;
					info.fw = 1'b0;
					info.rw = 1'b0;
				end
			end
			CMD_CMP: begin
				info.res = operand_a - operand_b;
				info.rw = 1'b0;
			end
			CMD_SHL: info.res = big_shift ? '0 : operand_a << sh;
			CMD_SHR: info.res = big_shift ? '0 : operand_a >> sh;
			CMD_SAR: info.res = big_shift ? fill : XLEN'($signed(operand_a) >>> sh);
			CMD_AND: info.res = operand_a & operand_b;
			CMD_OR:  info.res = operand_a | operand_b;
			CMD_XOR: info.res = operand_a ^ operand_b;
			CMD_NOT: info.res = ~operand_a;
			CMD_LDL: begin
				info.res = (operand_a & HIGH_HALF_MASK) | (operand_b & LOW_HALF_MASK);
				info.fw = 1'b0;
			end
			CMD_LDH: begin
				info.res = (operand_a & LOW_HALF_MASK) | {operand_b[15:0], 16'h0000};
				info.fw = 1'b0;
			end
			default: begin
				info.fw = 1'b0;
				info.rw = 1'b0;
			end
		endcase

		dinit.neg_a = operand_a[XLEN-1];
		dinit.neg_b = operand_b[XLEN-1];
		dinit.quo = operand_a[XLEN-1] ? (XLEN'(0) - operand_a) : operand_a;
		dinit.den = operand_b[XLEN-1] ? (XLEN'(0) - operand_b) : operand_b;
		dinit.rem = '0;
		dinit.b = operand_b;
	end

endmodule

// File: rtl/ialu_div_stage.sv
// One restoring-division stage: DIV_BITS_PER_STAGE quotient bits.
module ialu_div_stage (
	input  ialu_pkg::div_data_t din,
	output ialu_pkg::div_data_t dout
);
	import ialu_pkg::*;

	logic [XLEN:0]   trial;
	logic [XLEN-1:0] r;
	logic [XLEN-1:0] q;

	always_comb begin
		r = din.rem;
		q = din.quo;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			trial = {r, q[XLEN-1]} - {1'b0, din.den};
			q = {q[XLEN-2:0], 1'b0};
			if (!trial[XLEN]) begin
				r = trial[XLEN-1:0];
				q[0] = 1'b1;
			end else begin
				r = {r[XLEN-2:0], din.quo[XLEN-1-i]};
			end
		end
		dout = din;
		dout.rem = r;
		dout.quo = q;
	end

endmodule

// File: tb/tb_integer_alu_floored_division.sv
`timescale 1ns / 1ps

module tb_integer_alu_floored_division;
	import ialu_pkg::*;

	typedef struct {
		logic [CMDW-1:0] cmd;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
	} alu_op_t;

	typedef struct {
		logic [XLEN-1:0] res;
		logic [XLEN-1:0] rem;
		logic            n;
		logic            z;
		logic            fw;
		logic            rw;
		logic            err;
	} alu_res_t;

	localparam int LATENCY = DIV_STAGES + 3;
	localparam logic [XLEN-1:0] SIGN = 32'h8000_0000;
	localparam logic [CMDW-1:0] CMD_UNUSED0 = 4'd14;
	localparam logic [CMDW-1:0] CMD_UNUSED1 = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMDW-1:0] command = '0;
	logic [XLEN-1:0] operand_a = '0;
	logic [XLEN-1:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [XLEN-1:0] result_value;
	logic [XLEN-1:0] remainder_value;
	logic negative_flag, zero_flag, flags_written, result_written, error_code;

	alu_op_t  pending_ops[$];
	alu_res_t expected_results[$];
	int mismatches = 0;
	bit quiet = 0;
	int in_gap = 0;
	int out_gap = 0;

	integer_alu_floored_division u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [XLEN-1:0] mag(logic [XLEN-1:0] v);
		return v[XLEN-1] ? -v : v;
	endfunction

	function automatic alu_res_t alu_predict(alu_op_t op);
		alu_res_t r;
		logic [XLEN-1:0] qm, rm, ma, mb;
		logic na, nb;
		r.res = '0; r.rem = '0; r.fw = 1; r.rw = 1; r.err = 0;
		case (op.cmd)
			CMD_ADD: r.res = op.a + op.b;
			CMD_SUB: r.res = op.a - op.b;
			CMD_MUL: r.res = op.a * op.b;
			CMD_DIV: begin
				if (op.b == '0) begin
					r.fw = 0; r.rw = 0; r.err = 1;
				end else begin
					na = op.a[XLEN-1];
					nb = op.b[XLEN-1];
					ma = mag(op.a);
					mb = mag(op.b);
					qm = ma / mb;
					rm = ma % mb;
					r.res = (na != nb) ? -qm : qm;
					r.rem = na ? -rm : rm;
					// floor: step quotient down, pull remainder to divisor sign
					if (rm != '0 && na != nb) begin
						r.res = r.res - 1;
						r.rem = r.rem + op.b;
					end
				end
			end
			CMD_CMP: begin
				r.res = op.a - op.b;
				r.rw = 0;
			end
			CMD_SHL: r.res = (op.b >= 32) ? '0 : op.a << op.b[4:0];
			CMD_SHR: r.res = (op.b >= 32) ? '0 : op.a >> op.b[4:0];
			CMD_SAR: r.res = (op.b >= 32) ? {XLEN{op.a[XLEN-1]}}
				: XLEN'($signed(op.a) >>> op.b[4:0]);
			CMD_AND: r.res = op.a & op.b;
			CMD_OR:  r.res = op.a | op.b;
			CMD_XOR: r.res = op.a ^ op.b;
			CMD_NOT: r.res = ~op.a;
			CMD_LDL: begin
				r.res = (op.a & HIGH_HALF_MASK) | (op.b & LOW_HALF_MASK);
				r.fw = 0;
			end
			CMD_LDH: begin
				r.res = (op.a & LOW_HALF_MASK) | ((op.b & LOW_HALF_MASK) << 16);
				r.fw = 0;
			end
			default: begin
				r.res = op.a; r.fw = 0; r.rw = 0;
			end
		endcase
		r.n = r.res[XLEN-1];
		r.z = (r.res == '0);
		return r;
	endfunction

	function automatic logic [XLEN-1:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return SIGN;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(logic [CMDW-1:0] c, logic [XLEN-1:0] a, logic [XLEN-1:0] b);
		alu_op_t op;
		op.cmd = c; op.a = a; op.b = b;
		pending_ops.push_back(op);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			alu_op_t op;
			op.cmd = command; op.a = operand_a; op.b = operand_b;
			expected_results.push_back(alu_predict(op));
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_gap <= $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0 && arst_n) begin
				alu_op_t op;
				op = pending_ops.pop_front();
				command <= op.cmd;
				operand_a <= op.a;
				operand_b <= op.b;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction res=%h", result_value);
			end else begin
				alu_res_t e;
				e = expected_results.pop_front();
				if (result_value !== e.res || remainder_value !== e.rem ||
				    negative_flag !== e.n || zero_flag !== e.z ||
				    flags_written !== e.fw || result_written !== e.rw ||
				    error_code !== e.err) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("exp res=%h rem=%h n%b z%b fw%b rw%b e%b",
							e.res, e.rem, e.n, e.z, e.fw, e.rw, e.err);
						$display("got res=%h rem=%h n%b z%b fw%b rw%b e%b",
							result_value, remainder_value, negative_flag, zero_flag,
							flags_written, result_written, error_code);
					end
				end
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		push_op(CMD_ADD, 32'hFFFF_FFFF, 32'h1);
		push_op(CMD_SUB, 32'h0, 32'h1);
		push_op(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_DIV, 32'd7, 32'h0);
		push_op(CMD_DIV, SIGN, 32'hFFFF_FFFF);
		push_op(CMD_DIV, -32'sd7, 32'd2);
		push_op(CMD_DIV, 32'd7, -32'sd2);
		push_op(CMD_DIV, -32'sd7, -32'sd2);
		push_op(CMD_DIV, 32'd6, -32'sd3);
		push_op(CMD_CMP, 32'd5, 32'd5);
		push_op(CMD_SHL, 32'hFFFF_FFFF, 32'd32);
		push_op(CMD_SHL, 32'h1, 32'd31);
		push_op(CMD_SHR, SIGN, 32'hFFFF_FFFF);
		push_op(CMD_SAR, SIGN, 32'd100);
		push_op(CMD_SAR, SIGN, 32'd0);
		push_op(CMD_SAR, SIGN, 32'h0001_0001);
		push_op(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		push_op(CMD_OR, 32'h0, 32'h0);
		push_op(CMD_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_NOT, 32'h0, 32'hFFFF_FFFF);
		push_op(CMD_LDL, 32'h1234_5678, 32'hFFFF_ABCD);
		push_op(CMD_LDH, 32'h1234_5678, 32'hFFFF_ABCD);
		push_op(CMD_UNUSED0, 32'hDEAD_BEEF, 32'h1);
		push_op(CMD_UNUSED1, 32'h0, 32'h0);
		for (int i = 0; i < 800; i++) begin
			logic [XLEN-1:0] b;
			b = rand_operand();
			if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 70);
			push_op(CMDW'($urandom_range(0, 15)), rand_operand(), b);
		end
		wait (pending_ops.size() < 150);
		quiet = 1;
		// sample between edges so the driver and monitor have settled
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (LATENCY * 2) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("integer_alu_floored_division: match");
		else
			$display("integer_alu_floored_division: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("integer_alu_floored_division: mismatch");
		$finish;
	end

endmodule
